### design/cbmr_pkg.sv
package cbmr_pkg;

   // Item opcodes
   localparam logic [1:0] OP_READ  = 2'd0;
   localparam logic [1:0] OP_WRITE = 2'd1;
   localparam logic [1:0] OP_TICK  = 2'd2;

   // Result targets
   localparam logic [1:0] TGT_NONE = 2'd0;
   localparam logic [1:0] TGT_ROM  = 2'd1;
   localparam logic [1:0] TGT_RAM  = 2'd2;
   localparam logic [1:0] TGT_BUS  = 2'd3;

   // Configuration register indexes
   localparam logic [2:0] CSR_ROM_MASK  = 3'd0;
   localparam logic [2:0] CSR_RAM_MASK  = 3'd1;
   localparam logic [2:0] CSR_RAM_COUNT = 3'd2;
   localparam logic [2:0] CSR_HAS_RTC   = 3'd3;
   localparam logic [2:0] CSR_TICK_THR  = 3'd4;

   // Clock register selects
   localparam logic [3:0] CLK_SEC = 4'd8;
   localparam logic [3:0] CLK_MIN = 4'd9;
   localparam logic [3:0] CLK_HR  = 4'd10;
   localparam logic [3:0] CLK_DL  = 4'd11;
   localparam logic [3:0] CLK_DH  = 4'd12;

   localparam logic [7:0] OPEN_BUS  = 8'hFF;
   localparam logic [7:0] DH_MASK   = 8'hC1;
   localparam logic [7:0] DH_RESET  = 8'h40;
   localparam int         HALT_BIT  = 6;
   localparam int         CARRY_BIT = 7;

   localparam logic [6:0] SEC_LIMIT = 7'd60;
   localparam logic [5:0] HR_LIMIT  = 6'd24;

   typedef struct packed {
      logic [6:0]  rom_bank_mask;
      logic [2:0]  ram_sel_mask;
      logic [4:0]  ram_bank_count;
      logic        has_rtc;
      logic [15:0] tick_threshold;
   } cfg_type;

   typedef struct packed {
      logic [7:0] dh;
      logic [7:0] dl;
      logic [4:0] hr;
      logic [5:0] mn;
      logic [5:0] sc;
   } time_type;

   typedef struct packed {
      logic       tick;
      logic       latch;
      logic       wr;
      logic [7:0] data;
   } rtc_cmd_type;

   typedef struct packed {
      logic [1:0]  target;
      logic [20:0] mem_addr;
      logic        mem_write;
      logic [7:0]  read_data;
   } rsp_type;

endpackage

### design/cartridge_bank_mapper_rtc_core.sv
// Path: a word accepted on req is held in the input register, then in the result register
// that drives rsp; decode, bank update and clock step finish in a single pass between the two.
// Throughput: one word per cycle while rsp is not stalled.
// A stalled rsp holds its word while the input register still takes one more req word.
// Reset (synchronous, active high): RAM off, ROM bank 1, RAM bank 0, RAM mode, clock select
// seconds, clock zeroed and halted, configuration back to its defaults. No clearing pass.
module cartridge_bank_mapper_rtc_core import cbmr_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_opcode,
   input  logic [15:0] req_address,
   input  logic [7:0]  req_write_data,
   // response channel
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_target,
   output logic [20:0] rsp_mem_addr,
   output logic        rsp_mem_write,
   output logic [7:0]  rsp_read_data,
   // configuration write port
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   // Configuration registers
   cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_ROM_MASK:  cfg_in.rom_bank_mask  = csr_wdata[6:0];
            CSR_RAM_MASK:  cfg_in.ram_sel_mask   = csr_wdata[2:0];
            CSR_RAM_COUNT: cfg_in.ram_bank_count = csr_wdata[4:0];
            CSR_HAS_RTC:   cfg_in.has_rtc        = csr_wdata[0];
            CSR_TICK_THR:  cfg_in.tick_threshold = csr_wdata;
            default: ;     // indexes past the list are dropped
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{rom_bank_mask:  7'd127,
                     ram_sel_mask:   3'd3,
                     ram_bank_count: 5'd4,
                     has_rtc:        1'b1,
                     tick_threshold: 16'd1000};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Input register: hold one req word until the pass below can run on it
   logic        s1_valid_ff;
   logic [1:0]  s1_opcode_ff;
   logic [15:0] s1_address_ff;
   logic [7:0]  s1_write_data_ff;
   logic        s1_adv;
   logic        req_fire;

   // Result register
   logic        rsp_valid_ff;
   rsp_type     rsp_ff;
   rsp_type     result;

   // Advance the word in the input register whenever the result slot is free or draining
   assign s1_adv    = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || s1_adv;
   assign req_fire  = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_fire) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_adv) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_opcode_ff     <= req_opcode;
         s1_address_ff    <= req_address;
         s1_write_data_ff <= req_write_data;
      end
   end

   // Bank mapping and clock: state commits only when the word moves on
   rtc_cmd_type rtc_cmd;
   logic [3:0]  clock_reg_sel;
   logic [7:0]  rtc_rd_data;

   cbmr_map u_map (
      .clock         (clock),
      .reset         (reset),
      .fire          (s1_adv),
      .opcode        (s1_opcode_ff),
      .address       (s1_address_ff),
      .write_data    (s1_write_data_ff),
      .cfg           (cfg_ff),
      .rtc_rd_data   (rtc_rd_data),
      .rtc_cmd       (rtc_cmd),
      .clock_reg_sel (clock_reg_sel),
      .result        (result)
   );

   cbmr_rtc u_rtc (
      .clock          (clock),
      .reset          (reset),
      .cmd            (rtc_cmd),
      .reg_sel        (clock_reg_sel),
      .tick_threshold (cfg_ff.tick_threshold),
      .rd_data        (rtc_rd_data)
   );

   // Load the result register on advance; drop valid once the word is taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_adv) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) rsp_ff <= result;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_target    = rsp_ff.target;
   assign rsp_mem_addr  = rsp_ff.mem_addr;
   assign rsp_mem_write = rsp_ff.mem_write;
   assign rsp_read_data = rsp_ff.read_data;

`ifndef ASSERT_OFF
   a_accept_loads: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> s1_valid_ff)
      else $error("accepted req word missing from input register");

   a_adv_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      s1_adv |=> rsp_valid_ff)
      else $error("advanced word did not reach the result register");

   a_write_is_ram: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_mem_write |-> rsp_target == TGT_RAM && rsp_mem_addr[20:16] == 5'd0)
      else $error("memory write outside RAM target");
`endif

endmodule

### design/cbmr_rtc.sv
module cbmr_rtc import cbmr_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  rtc_cmd_type cmd,
   input  logic [3:0]  reg_sel,
   input  logic [15:0] tick_threshold,
   output logic [7:0]  rd_data
);

   time_type    live_ff, live_in;
   time_type    latch_ff, latch_in;
   logic [15:0] sub_ff, sub_in;
   time_type    adv;

   // Carry one second through the time fields
   always_comb begin
      logic [6:0] sec_inc;
      logic [6:0] min_inc;
      logic [5:0] hr_inc;
      logic [9:0] day_inc;
      sec_inc = {1'b0, live_ff.sc} + 7'd1;
      min_inc = {1'b0, live_ff.mn} + 7'd1;
      hr_inc  = {1'b0, live_ff.hr} + 6'd1;
      day_inc = {1'b0, live_ff.dh[0], live_ff.dl} + 10'd1;
      adv = live_ff;
      if (sec_inc < SEC_LIMIT) begin
         adv.sc = sec_inc[5:0];
      end else begin
         adv.sc = 6'(sec_inc - SEC_LIMIT);
         if (min_inc < SEC_LIMIT) begin
            adv.mn = min_inc[5:0];
         end else begin
            adv.mn = 6'(min_inc - SEC_LIMIT);
            if (hr_inc < HR_LIMIT) begin
               adv.hr = hr_inc[4:0];
            end else begin
               adv.hr = 5'(hr_inc - HR_LIMIT);
               if (day_inc[9]) begin
                  adv.dl = 8'd0;
                  adv.dh[0] = 1'b0;
                  adv.dh[CARRY_BIT] = 1'b1;
               end else begin
                  adv.dl = day_inc[7:0];
                  adv.dh[0] = day_inc[8];
               end
            end
         end
      end
   end

   always_comb begin
      logic [15:0] th;
      logic [15:0] sub_inc;
      logic [7:0]  dh_w;
      th      = (tick_threshold == 16'd0) ? 16'd1 : tick_threshold;
      sub_inc = sub_ff + 16'd1;
      dh_w    = cmd.data & DH_MASK;
      live_in  = live_ff;
      latch_in = latch_ff;
      sub_in   = sub_ff;
      if (cmd.tick && !live_ff.dh[HALT_BIT]) begin
         if (sub_inc >= th) begin
            sub_in  = 16'd0;
            live_in = adv;
         end else begin
            sub_in = sub_inc;
         end
      end
      if (cmd.wr) begin
         unique case (reg_sel)
            CLK_SEC: begin
               live_in.sc  = cmd.data[5:0];
               latch_in.sc = cmd.data[5:0];
            end
            CLK_MIN: begin
               live_in.mn  = cmd.data[5:0];
               latch_in.mn = cmd.data[5:0];
            end
            CLK_HR: begin
               live_in.hr  = cmd.data[4:0];
               latch_in.hr = cmd.data[4:0];
            end
            CLK_DL: begin
               live_in.dl  = cmd.data;
               latch_in.dl = cmd.data;
            end
            CLK_DH: begin
               // restart the sub-second count when halt toggles
               if (dh_w[HALT_BIT] != live_ff.dh[HALT_BIT]) sub_in = 16'd0;
               live_in.dh  = dh_w;
               latch_in.dh = dh_w;
            end
            default: ;
         endcase
      end
      if (cmd.latch) latch_in = live_ff;
   end

   always_comb begin
      unique case (reg_sel)
         CLK_SEC: rd_data = {2'b00, latch_ff.sc};
         CLK_MIN: rd_data = {2'b00, latch_ff.mn};
         CLK_HR:  rd_data = {3'b000, latch_ff.hr};
         CLK_DL:  rd_data = latch_ff.dl;
         CLK_DH:  rd_data = latch_ff.dh;
         default: rd_data = OPEN_BUS;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         live_ff  <= '{dh: DH_RESET, default: '0};
         latch_ff <= '{dh: DH_RESET, default: '0};
         sub_ff   <= 16'd0;
      end else begin
         live_ff  <= live_in;
         latch_ff <= latch_in;
         sub_ff   <= sub_in;
      end
   end

endmodule

### design/cbmr_map.sv
module cbmr_map import cbmr_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        fire,
   input  logic [1:0]  opcode,
   input  logic [15:0] address,
   input  logic [7:0]  write_data,
   input  cfg_type     cfg,
   input  logic [7:0]  rtc_rd_data,
   output rtc_cmd_type rtc_cmd,
   output logic [3:0]  clock_reg_sel,
   output rsp_type     result
);

   logic       ram_on_ff, ram_on_in;
   logic [6:0] rom_bank_ff, rom_bank_in;
   logic [2:0] ram_bank_ff, ram_bank_in;
   logic       clock_mode_ff, clock_mode_in;
   logic [3:0] clk_sel_ff, clk_sel_in;

   assign clock_reg_sel = clk_sel_ff;

   always_comb begin
      logic       in_ram_win;
      logic       present;
      logic [6:0] rom_v;
      in_ram_win = (address[15:13] == 3'b101);
      present    = ({2'b00, ram_bank_ff} < cfg.ram_bank_count);
      rom_v      = (write_data[6:0] == 7'd0) ? 7'd1 : write_data[6:0];

      ram_on_in     = ram_on_ff;
      rom_bank_in   = rom_bank_ff;
      ram_bank_in   = ram_bank_ff;
      clock_mode_in = clock_mode_ff;
      clk_sel_in    = clk_sel_ff;
      rtc_cmd       = '{data: write_data, default: 1'b0};
      result        = '0;

      case (opcode)
         OP_READ: begin
            if (address[15:14] == 2'b00) begin
               result.target   = TGT_ROM;
               result.mem_addr = {5'd0, address};
            end else if (address[15:14] == 2'b01) begin
               result.target   = TGT_ROM;
               result.mem_addr = {rom_bank_ff, address[13:0]};
            end else if (in_ram_win) begin
               if (ram_on_ff && !clock_mode_ff && present) begin
                  result.target   = TGT_RAM;
                  result.mem_addr = {5'd0, ram_bank_ff, address[12:0]};
               end else begin
                  result.target    = TGT_BUS;
                  result.read_data = (ram_on_ff && clock_mode_ff && cfg.has_rtc) ?
                                     rtc_rd_data : OPEN_BUS;
               end
            end
         end
         OP_WRITE: begin
            unique case (address[15:13])
               3'b000: ram_on_in = (write_data[3:0] == 4'hA);
               3'b001: rom_bank_in = rom_v & cfg.rom_bank_mask;
               3'b010: begin
                  if (write_data < 8'd8) begin
                     clock_mode_in = 1'b0;
                     ram_bank_in   = write_data[2:0] & cfg.ram_sel_mask;
                  end else if (write_data <= {4'd0, CLK_DH}) begin
                     clock_mode_in = 1'b1;
                     clk_sel_in    = write_data[3:0];
                  end
               end
               3'b011: rtc_cmd.latch = fire && cfg.has_rtc;
               3'b101: begin
                  if (ram_on_ff) begin
                     if (clock_mode_ff) begin
                        rtc_cmd.wr = fire;
                     end else if (present) begin
                        result.target    = TGT_RAM;
                        result.mem_write = 1'b1;
                        result.mem_addr  = {5'd0, ram_bank_ff, address[12:0]};
                     end
                  end
               end
               default: ;
            endcase
         end
         OP_TICK: rtc_cmd.tick = fire;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ram_on_ff     <= 1'b0;
         rom_bank_ff   <= 7'd1;
         ram_bank_ff   <= 3'd0;
         clock_mode_ff <= 1'b0;
         clk_sel_ff    <= CLK_SEC;
      end else if (fire) begin
         ram_on_ff     <= ram_on_in;
         rom_bank_ff   <= rom_bank_in;
         ram_bank_ff   <= ram_bank_in;
         clock_mode_ff <= clock_mode_in;
         clk_sel_ff    <= clk_sel_in;
      end
   end

endmodule
